>>> src/rdc_pkg.sv
package rdc_pkg;

  localparam int RADIX_W = 6;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  typedef struct packed {
    logic load;
    logic step;
    logic store;
    logic rd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic step_last;
    logic quot_zero;
    logic store_full;
    logic idx_zero;
    logic out_free;
  } sts_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

endpackage

>>> src/radix_digit_converter_core.sv
// Channel  Signals                                 Carries
// cfg      cfg_valid / cfg_ready, cfg_data[5:0]    radix register write
// in       in_valid / in_ready, value              one integer per transfer
// out      out_valid / out_ready, digit, last      one digit per transfer, MSD first
//
// Each digit is found on the bit-serial divider and written to the digit store;
// the digits are then read back from the store and loaded into the output register.
// Synchronous active-high reset; radix resets to 10.
// A stalled output holds the digit and pauses readback; a new value is taken
// while the final digit still waits in the output register.
module radix_digit_converter_core
  import rdc_pkg::*;
#(
  parameter int VALUE_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [RADIX_W-1:0]     cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [RADIX_W-1:0]     digit,
  output logic                   last
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = !rst;

  rdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rdc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .digit     (digit),
    .last      (last)
  );

endmodule

>>> src/rdc_ctrl.sv
module rdc_ctrl
  import rdc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.step_last) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (sts.quot_zero || sts.store_full) begin
          state_next = ST_RD;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.idx_zero ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state == ST_IDLE) && !rst;

`ifndef SYNTH
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.store, cmd.rd, cmd.emit}))
    else $error("more than one datapath command at once");

  a_store_next: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STORE) |=> (state == ST_DIV || state == ST_RD))
    else $error("bad state after store");

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.idx_zero) |=> in_ready)
    else $error("not ready after final digit");
`endif

endmodule

>>> src/rdc_datapath.sv
module rdc_datapath
  import rdc_pkg::*;
#(
  parameter int VALUE_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [RADIX_W-1:0]     cfg_data,
  input  logic [VALUE_WIDTH-1:0] value,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [RADIX_W-1:0]     digit,
  output logic                   last
);

  localparam int DEPTH = VALUE_WIDTH + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = $clog2(VALUE_WIDTH);

  logic [RADIX_W-1:0]     radix;
  logic [RADIX_W-1:0]     eff_radix;
  logic [VALUE_WIDTH-1:0] quot;
  logic [RADIX_W-1:0]     part;
  logic [SW-1:0]          step_cnt;
  logic [CW-1:0]          count;
  logic [AW-1:0]          rd_idx;
  logic [RADIX_W-1:0]     rd_data;
  logic [RADIX_W-1:0]     mem [DEPTH];

  logic [RADIX_W:0]       trial;
  logic [RADIX_W:0]       diff;
  logic                   ge;

  assign eff_radix = clamp_radix(radix);
  assign trial     = {part, quot[VALUE_WIDTH-1]};
  assign diff      = trial - {1'b0, eff_radix};
  assign ge        = (trial >= {1'b0, eff_radix});

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_valid) begin
      radix <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot     <= value;
      part     <= '0;
      step_cnt <= SW'(VALUE_WIDTH - 1);
    end else if (cmd.step) begin
      quot     <= {quot[VALUE_WIDTH-2:0], ge};
      part     <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      step_cnt <= step_cnt - SW'(1);
    end else if (cmd.store) begin
      part     <= '0;
      step_cnt <= SW'(VALUE_WIDTH - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= '0;
    end else if (cmd.store) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[count[AW-1:0]] <= part;
    end
    if (cmd.rd) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      rd_idx <= count[AW-1:0];
    end else if (cmd.emit) begin
      rd_idx <= rd_idx - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digit <= rd_data;
      last  <= (rd_idx == '0);
    end
  end

  assign sts.step_last  = (step_cnt == '0);
  assign sts.quot_zero  = (quot == '0);
  assign sts.store_full = (count == CW'(DEPTH - 1));
  assign sts.idx_zero   = (rd_idx == '0);
  assign sts.out_free   = !out_valid || out_ready;

`ifndef SYNTH
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (part < eff_radix))
    else $error("remainder not below radix");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted digit not presented");

  a_load_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (count == '0))
    else $error("digit count not cleared on load");
`endif

endmodule

>>> tb/sv/radix_digit_converter_core_test.sv
`timescale 1ns / 100ps

module radix_digit_converter_core_test;
  import rdc_pkg::*;

  localparam int VW = 31;

  typedef struct packed {
    logic [RADIX_W-1:0] digit;
    logic               last;
  } digit_t;

  // typed digits: first emitted digit leftmost, final digit at index 0
  typedef struct packed {
    logic [RADIX_W-1:0]      radix;
    logic [VW-1:0]           value;
    logic [3:0]              n_typed;
    logic [9:0][RADIX_W-1:0] typed;
  } row_t;

  localparam int N_ROWS = 22;
  localparam row_t ROWS [N_ROWS] = '{
    '{6'd10, 31'd0,          4'd1,  60'({6'd0})},
    '{6'd10, 31'd7,          4'd1,  60'({6'd7})},
    '{6'd10, 31'd10,         4'd2,  60'({6'd1, 6'd0})},
    '{6'd10, 31'd2147483647, 4'd10, {6'd2, 6'd1, 6'd4, 6'd7, 6'd4, 6'd8, 6'd3, 6'd6, 6'd4,
                                     6'd7}},
    '{6'd10, 31'd1234567,    4'd0,  60'd0},
    '{6'd10, 31'd1000000000, 4'd10, {6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
                                     6'd0}},
    '{6'd2,  31'd0,          4'd1,  60'({6'd0})},
    '{6'd2,  31'd1,          4'd1,  60'({6'd1})},
    '{6'd2,  31'd2147483647, 4'd0,  60'd0},
    '{6'd2,  31'd1431655765, 4'd0,  60'd0},
    '{6'd36, 31'd35,         4'd1,  60'({6'd35})},
    '{6'd36, 31'd36,         4'd2,  60'({6'd1, 6'd0})},
    '{6'd36, 31'd2147483647, 4'd0,  60'd0},
    '{6'd0,  31'd5,          4'd3,  60'({6'd1, 6'd0, 6'd1})},
    '{6'd1,  31'd6,          4'd3,  60'({6'd1, 6'd1, 6'd0})},
    '{6'd37, 31'd71,         4'd2,  60'({6'd1, 6'd35})},
    '{6'd63, 31'd1295,       4'd2,  60'({6'd35, 6'd35})},
    '{6'd16, 31'd2147483647, 4'd8,  60'({6'd7, 6'd15, 6'd15, 6'd15, 6'd15, 6'd15, 6'd15,
                                         6'd15})},
    '{6'd16, 31'd1073741824, 4'd8,  60'({6'd4, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0})},
    '{6'd16, 31'd0,          4'd1,  60'({6'd0})},
    '{6'd35, 31'd1224,       4'd2,  60'({6'd34, 6'd34})},
    '{6'd10, 31'd12345,      4'd0,  60'd0}
  };

  localparam int N_PHASES = 10;
  localparam int PER_PHASE = 13;
  localparam logic [RADIX_W-1:0] PHASE_RADIX [N_PHASES] = '{
    6'd3, 6'd2, 6'd36, 6'd7, 6'd0, 6'd63, 6'd16, 6'd35, 6'd8, 6'd10
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [RADIX_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VW-1:0]      value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [RADIX_W-1:0] digit;
  logic               last;

  digit_t             expected_digits [$];
  logic [RADIX_W-1:0] radix_setting = RADIX_RESET;
  int                 idle_pct = 0;
  int                 stall_left = 0;
  int                 errors = 0;

  radix_digit_converter_core #(
    .VALUE_WIDTH(VW)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .digit(digit),
    .last(last)
  );

  always #1 clk = ~clk;

  function automatic void convert_to_radix(input logic [VW-1:0] v,
                                           input logic [RADIX_W-1:0] raw);
    logic [VW-1:0]      rest;
    logic [RADIX_W-1:0] base;
    digit_t             msd_first [$];
    base = raw;
    if (raw < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (raw > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    rest = v;
    do begin
      msd_first.push_front(digit_t'{RADIX_W'(rest % VW'(base)), msd_first.size() == 0});
      rest = rest / VW'(base);
    end while (rest != 0);
    foreach (msd_first[i]) begin
      expected_digits.push_back(msd_first[i]);
    end
  endfunction

  function automatic logic [VW-1:0] random_value();
    logic [VW-1:0] v;
    int            w;
    v = VW'($urandom);
    w = $urandom_range(1, VW);
    case ($urandom_range(0, 9))
      0: begin
        v = '0;
      end
      1: begin
        v = '1;
      end
      default: begin
        v = v >> (VW - w);
      end
    endcase
    return v;
  endfunction

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    in_valid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    radix_setting = r;
  endtask

  task automatic send_number(input logic [VW-1:0] v, input logic [3:0] n_typed,
                             input logic [9:0][RADIX_W-1:0] typed);
    logic [3:0] k;
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    if (n_typed == 0) begin
      convert_to_radix(v, radix_setting);
    end else begin
      for (k = 4'd0; k < n_typed; k++) begin
        expected_digits.push_back(digit_t'{typed[n_typed - 4'd1 - k], k == n_typed - 4'd1});
      end
    end
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // hold ready low for random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 399) < idle_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_digits
    digit_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_digits.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual digit %0d last %0b",
                 $time, digit, last);
        errors++;
      end else begin
        want = expected_digits.pop_front();
        if (digit !== want.digit) begin
          $display("%0t: digit expected %0d actual %0d", $time, want.digit, digit);
          errors++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, last);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 20;
    foreach (ROWS[i]) begin
      if (ROWS[i].radix != radix_setting) begin
        write_radix(ROWS[i].radix);
      end
      send_number(ROWS[i].value, ROWS[i].n_typed, ROWS[i].typed);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_radix(PHASE_RADIX[p]);
      idle_pct = (p == N_PHASES - 1) ? 0 : (p % 3) * 25;
      repeat (PER_PHASE) begin
        send_number(random_value(), 4'd0, '0);
      end
    end

    in_valid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
